// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the channel busy meter RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== rtl/cbpm_pkg.sv =====
// Types and constants of the channel busy percentage meter.
// No dependencies.
`default_nettype none
package cbpm_pkg;
   localparam int unsigned TIME_W = 40;
   localparam int unsigned TOTAL_W = 48;
   localparam int unsigned CBP_W = 23;
   localparam int unsigned BUSY_W = 32;
   localparam int unsigned WIN_W = 24;
   localparam int unsigned WGT_W = 17;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETAIN = 2'd2;
   localparam logic [CBP_W-1:0] CBP_FULL = 23'd6553600;
   localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;
   localparam int unsigned PCT_DIV_W = 47;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVENT, ST_SCAN_RD, ST_SCAN, ST_SCAN_LAST, ST_DIV, ST_EWMA1, ST_EWMA2,
      ST_OUT, ST_PURGE_RD, ST_PURGE, ST_PURGE_LAST
   } state_type;

   typedef struct packed {
      logic event_go;
      logic scan_clear;
      logic scan_acc;
      logic div_start;
      logic ewma1;
      logic ewma2;
      logic out_load;
      logic purge_chk;
      logic purge_done;
      logic idx_clear;
      logic idx_inc;
   } cmd_type;

   typedef struct packed {
      logic win_zero;
      logic div_done;
      logic idx_last;
      logic purge_due;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/cbpm_if.sv =====
// Valid/ready channel interfaces for items and results.
// Depends on cbpm_pkg.
`default_nettype none
interface cbpm_req_if;
   import cbpm_pkg::*;
   logic valid;
   logic ready;
   logic action;
   logic busy_level;
   logic [TIME_W-1:0] now;
   modport source (output valid, action, busy_level, now, input ready);
   modport sink (input valid, action, busy_level, now, output ready);
endinterface

interface cbpm_rsp_if;
   import cbpm_pkg::*;
   logic valid;
   logic ready;
   logic [BUSY_W-1:0] busy_ticks;
   logic [CBP_W-1:0] raw_cbp;
   logic [CBP_W-1:0] smoothed_cbp;
   logic [TOTAL_W-1:0] total_busy;
   modport source (output valid, busy_ticks, raw_cbp, smoothed_cbp, total_busy,
      input ready);
   modport sink (input valid, busy_ticks, raw_cbp, smoothed_cbp, total_busy,
      output ready);
endinterface
`default_nettype wire

// ===== rtl/cbpm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module cbpm_ram #(
   parameter int unsigned WIDTH = 80,
   parameter int unsigned DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/cbpm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on cbpm_pkg.
`default_nettype none
module cbpm_div (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [cbpm_pkg::PCT_DIV_W-1:0] dividend,
   input  wire [cbpm_pkg::WIN_W-1:0]     divisor,
   output logic                           done,
   output logic [cbpm_pkg::CBP_W-1:0]    quotient
);
   import cbpm_pkg::*;
   localparam int unsigned CNT_W = $clog2(PCT_DIV_W + 1);
   logic [PCT_DIV_W-1:0] q_ff, q_in;
   logic [WIN_W:0] r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic [WIN_W:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      trial = {r_ff[WIN_W-1:0], q_ff[PCT_DIV_W-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = CNT_W'(PCT_DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[PCT_DIV_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[PCT_DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   // The last quotient bit is formed in the cycle that raises done.
   assign done = run_ff && (cnt_ff == CNT_W'(1));
   // The quotient stays below the full percentage only when busy < window; the datapath uses it only then.
   assign quotient = q_in[CBP_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/cbpm_datapath.sv =====
// Datapath: channel state, interval ring, window sum, percentage and EWMA.
// Depends on cbpm_pkg, cbpm_ram and cbpm_div.
`default_nettype none
`include "assert_macros.svh"
module cbpm_datapath #(
   parameter int unsigned MAX_INTERVALS = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire cbpm_pkg::cmd_type      cmd,
   output cbpm_pkg::sts_type           sts,
   input  wire                         item_load,
   input  wire                         in_busy,
   input  wire [cbpm_pkg::TIME_W-1:0]  in_now,
   input  wire                         csr_wr_en,
   input  wire [cbpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [cbpm_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output logic [cbpm_pkg::BUSY_W-1:0] o_busy_ticks,
   output logic [cbpm_pkg::CBP_W-1:0]  o_raw_cbp,
   output logic [cbpm_pkg::CBP_W-1:0]  o_smoothed_cbp,
   output logic [cbpm_pkg::TOTAL_W-1:0] o_total_busy
);
   import cbpm_pkg::*;
   localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
   localparam int unsigned SUM_W = TIME_W + IDX_W + 2;
   localparam int unsigned ST_W = TIME_W + 1;

   logic [WIN_W-1:0] window_ff;
   logic [WGT_W-1:0] weight_ff;
   logic [WIN_W-1:0] retain_ff;
   logic busy_flag_ff, idle_flag_ff;
   logic [TIME_W-1:0] start_ff, now_ff, purge_time_ff;
   logic item_busy_ff;
   logic [IDX_W-1:0] slot_ff, idx_ff;
   logic [MAX_INTERVALS-1:0] valid_ff;
   logic [CBP_W-1:0] prev_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CBP_W-1:0] raw_ff;
   logic [40:0] prod_a_ff, prod_b_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic rd_valid_ff;

   logic [2*TIME_W-1:0] rd_data;
   logic rec;
   logic [TIME_W-1:0] fin;
   logic [CBP_W-1:0] quot;
   logic div_done;

   // Recording a finished interval on an idle event.
   assign rec = cmd.event_go && !item_busy_ff && !idle_flag_ff && (start_ff != '0);
   assign fin = (now_ff >= start_ff) ? now_ff : start_ff;

   cbpm_ram #(.WIDTH(2*TIME_W), .DEPTH(MAX_INTERVALS)) u_ram (
      .clock(clock), .wr_en(rec), .wr_addr(slot_ff), .wr_data({start_ff, fin}),
      .rd_addr(idx_ff), .rd_data(rd_data)
   );

   // Signed window start and interval contribution.
   logic signed [ST_W:0] ws, tb, tf, tn, tlim;
   logic [TIME_W-1:0] contrib;
   assign ws = $signed({2'b00, now_ff}) - $signed({{(ST_W+1-WIN_W){1'b0}}, window_ff});
   assign tb = $signed({2'b00, rd_data[2*TIME_W-1:TIME_W]});
   assign tf = $signed({2'b00, rd_data[TIME_W-1:0]});
   assign tn = $signed({2'b00, now_ff});
   assign tlim = tn - $signed({{(ST_W+1-WIN_W){1'b0}}, retain_ff});
   always_comb begin
      contrib = '0;
      if (tb >= ws && tb <= tn) begin
         if (tf > tb) contrib = TIME_W'(tf - tb);
      end else if (tb < ws && tf > ws) begin
         contrib = TIME_W'(tf - ws);
      end
   end

   logic [WGT_W-1:0] w_eff;
   assign w_eff = (weight_ff > ONE_Q16) ? ONE_Q16 : weight_ff;
   logic [42:0] sm_sum;
   logic [CBP_W-1:0] sm;
   assign sm_sum = {2'b00, prod_a_ff} + {2'b00, prod_b_ff} + 43'd32768;
   assign sm = (sm_sum[42:16] > 27'(CBP_FULL)) ? CBP_FULL : sm_sum[16+CBP_W-1:16];

   cbpm_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(PCT_DIV_W'(sum_ff[BUSY_W-1:0]) * PCT_DIV_W'(CBP_FULL)),
      .divisor(window_ff), .done(div_done), .quotient(quot)
   );

   assign sts.win_zero = (window_ff == '0);
   assign sts.div_done = div_done;
   assign sts.idx_last = (idx_ff == IDX_W'(MAX_INTERVALS - 1));
   assign sts.purge_due = (now_ff >= purge_time_ff) &&
      ((now_ff - purge_time_ff) >= TIME_W'(retain_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 24'd100000;
         weight_ff <= 17'd32768;
         retain_ff <= 24'd6000000;
         busy_flag_ff <= 1'b0;
         idle_flag_ff <= 1'b0;
         start_ff <= '0;
         slot_ff <= '0;
         valid_ff <= '0;
         prev_ff <= '0;
         total_ff <= '0;
         purge_time_ff <= '0;
         idx_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW: window_ff <= csr_wr_data;
               CSR_WEIGHT: weight_ff <= csr_wr_data[WGT_W-1:0];
               CSR_RETAIN: retain_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.event_go) begin
            if (item_busy_ff) begin
               if (!busy_flag_ff) start_ff <= now_ff;
               busy_flag_ff <= 1'b1;
               idle_flag_ff <= 1'b0;
            end else begin
               busy_flag_ff <= 1'b0;
               idle_flag_ff <= 1'b1;
            end
         end
         if (rec) begin
            valid_ff[slot_ff] <= 1'b1;
            slot_ff <= (slot_ff == IDX_W'(MAX_INTERVALS - 1)) ? '0 : slot_ff + 1'b1;
            total_ff <= total_ff + TOTAL_W'(fin - start_ff);
         end
         if (cmd.idx_clear) idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
         rd_valid_ff <= valid_ff[idx_ff];
         if (cmd.purge_chk && rd_valid_ff && (tf < tlim)) valid_ff[rd_idx_ff] <= 1'b0;
         if (cmd.purge_done) purge_time_ff <= now_ff;
         if (cmd.out_load) prev_ff <= sts.win_zero ? '0 : sm;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (item_load) begin
         now_ff <= in_now;
         item_busy_ff <= in_busy;
      end
      if (cmd.scan_clear) begin
         sum_ff <= (busy_flag_ff && now_ff >= start_ff) ? SUM_W'(now_ff - start_ff) : '0;
      end else if (cmd.scan_acc && rd_valid_ff) begin
         sum_ff <= sum_ff + SUM_W'(contrib);
      end
      if (cmd.div_start) raw_ff <= CBP_FULL;
      if (div_done && sum_ff < SUM_W'(window_ff)) raw_ff <= quot;
      if (cmd.ewma1) prod_a_ff <= 41'(w_eff) * 41'(raw_ff);
      if (cmd.ewma2) prod_b_ff <= 41'(ONE_Q16 - w_eff) * 41'(prev_ff);
      if (cmd.out_load) begin
         o_total_busy <= total_ff;
         if (sts.win_zero) begin
            o_busy_ticks <= '0;
            o_raw_cbp <= '0;
            o_smoothed_cbp <= '0;
         end else begin
            o_busy_ticks <= (sum_ff > SUM_W'(32'hFFFFFFFF)) ? '1 : sum_ff[BUSY_W-1:0];
            o_raw_cbp <= raw_ff;
            o_smoothed_cbp <= sm;
         end
      end
   end

   `ASSERT_IMPL(a_prev_bound, clock, reset, 1'b1, prev_ff <= CBP_FULL)
   `ASSERT_NEXT(a_rec_slot, clock, reset, rec && slot_ff == IDX_W'(MAX_INTERVALS - 1),
      slot_ff == '0)
endmodule
`default_nettype wire

// ===== rtl/cbpm_ctrl.sv =====
// Controller: sequences events, window scan, division, EWMA, output and purge.
// Depends on cbpm_pkg.
`default_nettype none
`include "assert_macros.svh"
module cbpm_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_fire,
   input  wire                    req_action,
   input  wire                    rsp_taken,
   input  wire cbpm_pkg::sts_type sts,
   output cbpm_pkg::cmd_type      cmd,
   output logic                   req_ready,
   output logic                   rsp_valid
);
   import cbpm_pkg::*;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) state_in = req_action ? ST_SCAN_RD : ST_EVENT;
         end
         ST_EVENT: begin
            cmd.event_go = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN_RD: begin
            cmd.scan_clear = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in = sts.win_zero ? ST_OUT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_acc = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last) state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: begin
            cmd.scan_acc = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_EWMA1;
         end
         ST_EWMA1: begin
            if (sts.div_done) state_in = ST_EWMA2;
         end
         ST_EWMA2: begin
            cmd.ewma1 = 1'b1;
            cmd.ewma2 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in = (!sts.win_zero && sts.purge_due) ? ST_PURGE_RD : ST_IDLE;
            end
         end
         ST_PURGE_RD: begin
            cmd.idx_inc = 1'b1;
            state_in = ST_PURGE;
         end
         ST_PURGE: begin
            cmd.purge_chk = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last) state_in = ST_PURGE_LAST;
         end
         ST_PURGE_LAST: begin
            cmd.purge_chk = 1'b1;
            cmd.purge_done = 1'b1;
            cmd.idx_clear = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_valid_ff)
   `ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
endmodule
`default_nettype wire

// ===== rtl/channel_busy_percentage_meter_unit.sv =====
// Top level of the channel busy percentage meter.
// Depends on cbpm_pkg, cbpm_if, cbpm_ctrl and cbpm_datapath.
//
//   channel | direction | payload
//   req     | in        | action, busy_level, now
//   rsp     | out       | busy_ticks, raw_cbp, smoothed_cbp, total_busy
//   csr     | in        | csr_wr_en, csr_index, csr_wr_data
//
// A compute request reads every ring slot in turn, then runs the percentage
// divider; a zero window skips both.
// A purge then checks one ring entry per cycle.
// Reset is synchronous; the ring needs no clearing pass.
// A stalled result is held; the next item is taken while it waits.
`default_nettype none
module channel_busy_percentage_meter_unit #(
   parameter int unsigned MAX_INTERVALS = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   cbpm_req_if.sink                         req,
   cbpm_rsp_if.source                       rsp,
   input  wire                              csr_wr_en,
   input  wire [cbpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [cbpm_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import cbpm_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic req_fire;

   assign req_fire = req.valid && req.ready;

   cbpm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_action(req.action),
      .rsp_taken(rsp.valid && rsp.ready), .sts(sts), .cmd(cmd),
      .req_ready(req.ready), .rsp_valid(rsp.valid)
   );

   cbpm_datapath #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .item_load(req_fire),
      .in_busy(req.busy_level), .in_now(req.now), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .o_busy_ticks(rsp.busy_ticks), .o_raw_cbp(rsp.raw_cbp),
      .o_smoothed_cbp(rsp.smoothed_cbp), .o_total_busy(rsp.total_busy)
   );
endmodule
`default_nettype wire
